// ===== sv/crl_pkg.sv =====
// Shared types and constants for the Catmull-Rom loop evaluator.
`default_nettype none
package crl_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned CountW = 7;
  localparam int unsigned SegW   = 6;
  // Headroom for doubled basis coefficients and Horner sums.
  localparam int unsigned AccW   = 40;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic signed [AccW-1:0] a3;
    logic signed [AccW-1:0] a2;
    logic signed [AccW-1:0] a1;
    logic signed [AccW-1:0] a0;
  } coef_t;

  // Clip to 32 bits; flag set when clipped.
  function automatic logic [CoordW:0] clip32(input logic signed [AccW-1:0] v);
    logic [CoordW:0] r;
    if (v > $signed({{(AccW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}})) begin
      r = {1'b1, 1'b0, {(CoordW-1){1'b1}}};
    end else if (v < -$signed({{(AccW-CoordW){1'b0}}, 1'b1, {(CoordW-1){1'b0}}})) begin
      r = {1'b1, 1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, v[CoordW-1:0]};
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/crl_axis.sv =====
// One axis of the datapath: basis coefficients, Horner steps, rounding, clipping.
`default_nettype none
module crl_axis #(
  parameter int unsigned T_BITS = 16
) (
  input  wire                                    clk_i,
  input  wire signed [crl_pkg::CoordW-1:0]       p0_i,
  input  wire signed [crl_pkg::CoordW-1:0]       p1_i,
  input  wire signed [crl_pkg::CoordW-1:0]       p2_i,
  input  wire signed [crl_pkg::CoordW-1:0]       p3_i,
  input  wire        [T_BITS-1:0]                t_i,
  output logic       [crl_pkg::CoordW-1:0]       pos_o,
  output logic       [crl_pkg::CoordW-1:0]       deriv_o,
  output logic                                   sat_o
);
  localparam int unsigned AW = crl_pkg::AccW;
  localparam int unsigned PW = AW + T_BITS + 1;

  function automatic logic signed [AW-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    s = (v + (PW'(1) <<< (T_BITS-1))) >>> T_BITS;
    return s[AW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] mul(input logic signed [AW-1:0] h,
                                               input logic [T_BITS-1:0] t);
    logic signed [PW-1:0] p;
    p = PW'(h) * $signed({1'b0, t});
    return rnd(p);
  endfunction

  logic signed [AW-1:0] e0, e1, e2, e3;
  assign e0 = AW'(p0_i);
  assign e1 = AW'(p1_i);
  assign e2 = AW'(p2_i);
  assign e3 = AW'(p3_i);

  // stage 1: coefficients
  crl_pkg::coef_t c_q;
  logic [T_BITS-1:0] t1_q, t2_q, t3_q;
  always_ff @(posedge clk_i) begin
    c_q.a3 <= -e0 + 3*e1 - 3*e2 + e3;
    c_q.a2 <= 2*e0 - 5*e1 + 4*e2 - e3;
    c_q.a1 <= e2 - e0;
    c_q.a0 <= 2*e1;
    t1_q   <= t_i;
  end

  // stage 2: first Horner step
  logic signed [AW-1:0] h2_q, d2_q, a1_2_q, a0_2_q, a0_3_q;
  always_ff @(posedge clk_i) begin
    h2_q   <= mul(c_q.a3, t1_q) + c_q.a2;
    d2_q   <= mul(3*c_q.a3, t1_q) + 2*c_q.a2;
    a1_2_q <= c_q.a1;
    a0_2_q <= c_q.a0;
    t2_q   <= t1_q;
  end

  // stage 3: second step
  logic signed [AW-1:0] h3_q, d3_q;
  always_ff @(posedge clk_i) begin
    h3_q   <= mul(h2_q, t2_q) + a1_2_q;
    d3_q   <= mul(d2_q, t2_q) + a1_2_q;
    a0_3_q <= a0_2_q;
    t3_q   <= t2_q;
  end

  // stage 4: last step, halve, clip
  logic signed [AW-1:0] h4, dh;
  logic [crl_pkg::CoordW:0] cp, cd;
  always_comb begin
    h4 = (mul(h3_q, t3_q) + a0_3_q + AW'(1)) >>> 1;
    dh = (d3_q + AW'(1)) >>> 1;
    cp = crl_pkg::clip32(h4);
    cd = crl_pkg::clip32(dh);
  end
  always_ff @(posedge clk_i) begin
    pos_o   <= cp[crl_pkg::CoordW-1:0];
    deriv_o <= cd[crl_pkg::CoordW-1:0];
    sat_o   <= cp[crl_pkg::CoordW] | cd[crl_pkg::CoordW];
  end
endmodule
`default_nettype wire

// ===== sv/catmull_rom_loop_evaluator.sv =====
// Top level: point table, segment selection and three axis pipelines.
//  channel | signals                           | handshake
//  request | start_i, busy_o, req_type_i, ...  | taken when start_i & !busy_o
//  result  | done_o, pos_*_o, deriv_*_o, ...   | one-cycle strobe, no backpressure
//  config  | cfg_valid_i, cfg_ready_o, cfg_data_i | valid & ready
// One request per cycle; busy_o is always low. An evaluation request passes
// the scale stage, the index stage (four wrapped indices), the table read, then four
// arithmetic stages. The table is kept in two copies, each read at two ports;
// point writes pass the wv1_q and wv2_q registers and land at the table-read stage.
// Reset clears valid bits and the point count (to 4); table content is
// undefined until written. The receiver cannot stall, so nothing ever holds.
`default_nettype none
module catmull_rom_loop_evaluator #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned T_BITS     = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire         req_type_i,
  input  wire  [5:0]  point_index_i,
  input  wire  [31:0] point_x_i,
  input  wire  [31:0] point_y_i,
  input  wire  [31:0] point_z_i,
  input  wire  [15:0] global_t_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [6:0]  cfg_data_i,
  output logic        done_o,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [31:0] pos_z_o,
  output logic [31:0] deriv_x_o,
  output logic [31:0] deriv_y_o,
  output logic [31:0] deriv_z_o,
  output logic [5:0]  segment_o,
  output logic        saturated_o
);
  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned LAT = 4;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [6:0] count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 7'd4;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // effective count, clamped to 1..MAX_POINTS
  logic [NW-1:0] n;
  always_comb begin
    if (count_q == '0) n = NW'(1);
    else if (32'(count_q) > MAX_POINTS) n = NW'(MAX_POINTS);
    else n = NW'(count_q);
  end

  logic acc;
  assign acc = start_i & ~busy_o;

  // Delay point writes so they reach the table in request order with evaluations.
  logic wv1_q, wv2_q;
  logic [IW-1:0] wi1_q, wi2_q;
  logic [3*crl_pkg::CoordW-1:0] wd1_q, wd2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv1_q <= 1'b0; wv2_q <= 1'b0;
    end else begin
      wv1_q <= acc && req_type_i == crl_pkg::REQ_WRITE && 32'(point_index_i) < MAX_POINTS;
      wv2_q <= wv1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    wi1_q <= IW'(point_index_i);
    wd1_q <= {point_z_i, point_y_i, point_x_i};
    wi2_q <= wi1_q;
    wd2_q <= wd1_q;
  end

  logic [3*crl_pkg::CoordW-1:0] mem_a [MAX_POINTS];
  logic [3*crl_pkg::CoordW-1:0] mem_b [MAX_POINTS];
  always_ff @(posedge clk_i) begin
    if (wv2_q) begin
      mem_a[wi2_q] <= wd2_q;
      mem_b[wi2_q] <= wd2_q;
    end
  end

  // s1: scale
  logic v1_q, v2_q, v3_q;
  logic [T_BITS+NW-1:0] s1_q;
  logic [NW-1:0] n1_q;
  always_ff @(posedge clk_i) begin
    s1_q <= (T_BITS+NW)'(T_BITS'(global_t_i)) * (T_BITS+NW)'(n);
    n1_q <= n;
  end

  // s2: wrapped indices
  logic [IW-1:0] i0_q, i1_q, i2_q, i3_q;
  logic [IW-1:0] i0_d, i1_d, i2_d, i3_d;
  logic [T_BITS-1:0] t2_q, t3_q;
  logic [5:0] seg2_q, seg3_q;
  always_comb begin : idx
    logic [NW:0] sg, a, b, c, d;
    sg = (NW+1)'(s1_q[T_BITS+NW-1:T_BITS]);
    a = (sg == 0) ? (NW+1)'(n1_q) - 1'b1 : sg - 1'b1;
    b = (a + 1'b1 >= (NW+1)'(n1_q)) ? a + 1'b1 - (NW+1)'(n1_q) : a + 1'b1;
    c = (b + 1'b1 >= (NW+1)'(n1_q)) ? b + 1'b1 - (NW+1)'(n1_q) : b + 1'b1;
    d = (c + 1'b1 >= (NW+1)'(n1_q)) ? c + 1'b1 - (NW+1)'(n1_q) : c + 1'b1;
    i0_d = a[IW-1:0]; i1_d = b[IW-1:0]; i2_d = c[IW-1:0]; i3_d = d[IW-1:0];
  end
  always_ff @(posedge clk_i) begin
    i0_q <= i0_d; i1_q <= i1_d; i2_q <= i2_d; i3_q <= i3_d;
    t2_q   <= s1_q[T_BITS-1:0];
    seg2_q <= 6'(s1_q[T_BITS+NW-1:T_BITS]);
  end

  // s3: table read
  logic [3*crl_pkg::CoordW-1:0] r0_q, r1_q, r2_q, r3_q;
  always_ff @(posedge clk_i) begin
    r0_q <= mem_a[i0_q]; r1_q <= mem_a[i1_q]; r2_q <= mem_b[i2_q]; r3_q <= mem_b[i3_q];
    t3_q <= t2_q;
    seg3_q <= seg2_q;
  end

  logic [LAT-1:0] vp_q;
  logic [5:0] segp_q [LAT];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; vp_q <= '0;
    end else begin
      v1_q <= acc & (req_type_i == crl_pkg::REQ_EVAL);
      v2_q <= v1_q;
      v3_q <= v2_q;
      vp_q <= {vp_q[LAT-2:0], v3_q};
    end
  end
  always_ff @(posedge clk_i) begin
    segp_q[0] <= seg3_q;
    for (int k = 1; k < LAT; k++) segp_q[k] <= segp_q[k-1];
  end

  logic [2:0] sat;
  logic [31:0] pos [3];
  logic [31:0] der [3];
  for (genvar a = 0; a < 3; a++) begin : g_axis
    crl_axis #(.T_BITS(T_BITS)) u_axis (
      .clk_i   (clk_i),
      .p0_i    (r0_q[a*32 +: 32]),
      .p1_i    (r1_q[a*32 +: 32]),
      .p2_i    (r2_q[a*32 +: 32]),
      .p3_i    (r3_q[a*32 +: 32]),
      .t_i     (t3_q),
      .pos_o   (pos[a]),
      .deriv_o (der[a]),
      .sat_o   (sat[a])
    );
  end

  assign done_o      = vp_q[LAT-1];
  assign pos_x_o     = pos[0];
  assign pos_y_o     = pos[1];
  assign pos_z_o     = pos[2];
  assign deriv_x_o   = der[0];
  assign deriv_y_o   = der[1];
  assign deriv_z_o   = der[2];
  assign segment_o   = segp_q[LAT-1];
  assign saturated_o = |sat;
endmodule
`default_nettype wire

// ===== sv/crl_checker.sv =====
// Port-level checks for the Catmull-Rom loop evaluator, bound to the top level.
`default_nettype none
module crl_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire start_i,
  input wire busy_o,
  input wire req_type_i,
  input wire done_o,
  input wire cfg_ready_o
);
  a_done_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && req_type_i, 7))
    else $error("result without evaluate request");
  a_write_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !req_type_i) |-> ##7 !done_o)
    else $error("write request produced a result");
  a_eval_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i) |-> ##7 done_o)
    else $error("evaluate request lost");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && cfg_ready_o)
    else $error("block stalled");
endmodule

bind catmull_rom_loop_evaluator crl_checker u_crl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .req_type_i(req_type_i), .done_o(done_o), .cfg_ready_o(cfg_ready_o)
);
`default_nettype wire

// ===== tb/tb_catmull_rom_loop_evaluator.sv =====
// Testbench for the closed-loop Catmull-Rom evaluator: streams point writes and evaluations.
module tb_catmull_rom_loop_evaluator;

  localparam int unsigned NumSlots    = 64;
  localparam int unsigned TBits       = 16;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned StallLimit  = 2000;

  typedef struct {
    logic [31:0] pos_x, pos_y, pos_z;
    logic [31:0] der_x, der_y, der_z;
    logic [5:0]  seg;
    logic        sat;
  } curve_sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        req_type_i;
  logic [5:0]  point_index_i;
  logic [31:0] point_x_i, point_y_i, point_z_i;
  logic [15:0] global_t_i;
  logic        cfg_valid_i;
  logic [6:0]  cfg_data_i;
  logic        busy_o, cfg_ready_o, done_o, saturated_o;
  logic [31:0] pos_x_o, pos_y_o, pos_z_o, deriv_x_o, deriv_y_o, deriv_z_o;
  logic [5:0]  segment_o;

  // Model state.
  logic signed [31:0] pt_table [NumSlots][3];
  logic [6:0]         pt_count;
  curve_sample_t      pending_samples[$];

  int unsigned mismatches  = 0;
  int unsigned evals_sent  = 0;
  int unsigned writes_sent = 0;
  int unsigned samples_ok  = 0;
  int unsigned cfg_writes  = 0;
  int unsigned sat_seen    = 0;
  int unsigned stall_cnt   = 0;

  catmull_rom_loop_evaluator u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .point_index_i,
    .point_x_i, .point_y_i, .point_z_i, .global_t_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .done_o, .pos_x_o, .pos_y_o, .pos_z_o, .deriv_x_o, .deriv_y_o, .deriv_z_o,
    .segment_o, .saturated_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // floor((v + 2^(k-1)) / 2^k)
  function automatic longint round_shift(input longint v, input int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic logic [31:0] clip_coord(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic curve_sample_t eval_curve(input logic [15:0] gt);
    curve_sample_t r;
    int unsigned   n, s, seg;
    int unsigned   slot [4];
    longint        t, p0, p1, p2, p3, a3, a2, a1, a0, h;
    logic          sat;
    logic [31:0]   pv [3];
    logic [31:0]   dv [3];
    n = 32'(pt_count);
    if (n == 0) n = 1;
    if (n > NumSlots) n = NumSlots;
    s   = 32'(gt) * n;
    seg = s >> TBits;
    t   = longint'(s & ((1 << TBits) - 1));
    slot[0] = (seg + n - 1) % n;
    for (int k = 1; k < 4; k++) slot[k] = (slot[k-1] + 1) % n;
    sat = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      p0 = longint'(pt_table[slot[0]][ax]);
      p1 = longint'(pt_table[slot[1]][ax]);
      p2 = longint'(pt_table[slot[2]][ax]);
      p3 = longint'(pt_table[slot[3]][ax]);
      a3 = -p0 + 3 * p1 - 3 * p2 + p3;
      a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      a1 = -p0 + p2;
      a0 = 2 * p1;
      h = round_shift(a3 * t, TBits) + a2;
      h = round_shift(h * t, TBits) + a1;
      h = round_shift(h * t, TBits) + a0;
      pv[ax] = clip_coord(round_shift(h, 1), sat);
      h = round_shift(3 * a3 * t, TBits) + 2 * a2;
      h = round_shift(h * t, TBits) + a1;
      dv[ax] = clip_coord(round_shift(h, 1), sat);
    end
    r.pos_x = pv[0]; r.pos_y = pv[1]; r.pos_z = pv[2];
    r.der_x = dv[0]; r.der_y = dv[1]; r.der_z = dv[2];
    r.seg = seg[5:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h expected %h", what, got, want);
  endtask

  // Send one request, hold until taken, then idle for a random gap.
  task automatic send_request(input crl_pkg::req_type_e kind, input logic [5:0] idx,
                              input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [15:0] gt);
    int unsigned gap;
    start_i       <= 1'b1;
    req_type_i    <= kind;
    point_index_i <= idx;
    point_x_i     <= x;
    point_y_i     <= y;
    point_z_i     <= z;
    global_t_i    <= gt;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    if (kind == crl_pkg::REQ_WRITE) begin
      pt_table[idx][0] = x;
      pt_table[idx][1] = y;
      pt_table[idx][2] = z;
      writes_sent++;
    end else begin
      pending_samples.insert(pending_samples.size(), eval_curve(gt));
      evals_sent++;
    end
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_point_count(input logic [6:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pt_count = value;
    cfg_writes++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 'h1ffff)) - 'h10000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_param();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_slot(input logic [5:0] idx);
    send_request(crl_pkg::REQ_WRITE, idx, rand_coord(), rand_coord(), rand_coord(), '0);
  endtask

  task automatic eval_at(input logic [15:0] gt);
    send_request(crl_pkg::REQ_EVAL, '0, '0, '0, '0, gt);
  endtask

  // Reset count of four: alternating extremes force clipping, plus boundary t.
  task automatic test_directed();
    send_request(crl_pkg::REQ_WRITE, 6'd0, 32'h7fff_ffff, 32'h0001_0000, 32'h0, '0);
    send_request(crl_pkg::REQ_WRITE, 6'd1, 32'h8000_0000, 32'hffff_0000, 32'h0, '0);
    send_request(crl_pkg::REQ_WRITE, 6'd2, 32'h7fff_ffff, 32'h0002_0000, 32'h0, '0);
    send_request(crl_pkg::REQ_WRITE, 6'd3, 32'h8000_0000, 32'h0000_8000, 32'h0, '0);
    eval_at(16'h0000);
    eval_at(16'h0001);
    eval_at(16'h3fff);
    eval_at(16'h4000);
    eval_at(16'h8000);
    eval_at(16'hbfff);
    eval_at(16'hffff);
    send_request(crl_pkg::REQ_WRITE, 6'd1, 32'h0, 32'h0, 32'h0, '0);
    eval_at(16'h2000);
    eval_at(16'h6000);
  endtask

  task automatic test_fill_table();
    for (int i = 0; i < NumSlots; i++) write_slot(6'(i));
  endtask

  // Mostly evaluations with the given point count, with rewrites mixed in.
  task automatic test_count_phase(input logic [6:0] count, input int unsigned items);
    write_point_count(count);
    repeat (items) begin
      if ($urandom_range(0, 3) == 0) write_slot(6'($urandom_range(0, 63)));
      else eval_at(rand_param());
    end
  endtask

  always @(negedge clk_i) begin
    curve_sample_t want;
    if (rst_ni && done_o) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected result, segment", 32'(segment_o), '0);
      end else begin
        want = pending_samples.pop_front();
        if (pos_x_o !== want.pos_x) report_mismatch("pos_x", pos_x_o, want.pos_x);
        if (pos_y_o !== want.pos_y) report_mismatch("pos_y", pos_y_o, want.pos_y);
        if (pos_z_o !== want.pos_z) report_mismatch("pos_z", pos_z_o, want.pos_z);
        if (deriv_x_o !== want.der_x) report_mismatch("deriv_x", deriv_x_o, want.der_x);
        if (deriv_y_o !== want.der_y) report_mismatch("deriv_y", deriv_y_o, want.der_y);
        if (deriv_z_o !== want.der_z) report_mismatch("deriv_z", deriv_z_o, want.der_z);
        if (segment_o !== want.seg) begin
          report_mismatch("segment", 32'(segment_o), 32'(want.seg));
        end
        if (saturated_o !== want.sat) begin
          report_mismatch("saturated", 32'(saturated_o), 32'(want.sat));
        end
        if (want.sat) sat_seen++;
        samples_ok++;
      end
    end
  end

  // Abort when no request, config write or result moves for too long.
  always @(negedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("watchdog expired after %0d idle cycles", stall_cnt);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    req_type_i    <= crl_pkg::REQ_WRITE;
    point_index_i <= '0;
    point_x_i     <= '0;
    point_y_i     <= '0;
    point_z_i     <= '0;
    global_t_i    <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    pt_count       = 7'd4;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_table();
    test_count_phase(7'd1, 150);
    test_count_phase(7'd64, 250);
    test_count_phase(7'd0, 100);
    test_count_phase(7'd127, 150);
    test_count_phase(7'd65, 100);
    test_count_phase(7'd2, 150);
    test_count_phase(7'd3, 150);
    test_count_phase(7'd4, 150);
    test_count_phase(7'($urandom_range(5, 63)), 250);
    test_count_phase(7'($urandom_range(5, 127)), 250);

    wait_idle();
    $display("covered %0d evaluations (%0d clipped) and %0d point writes",
             samples_ok, sat_seen, writes_sent);
    $display("across %0d point count settings incl. 0, 1, 64, 65 and 127", cfg_writes);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/crl_pkg.sv
sv/crl_axis.sv
sv/catmull_rom_loop_evaluator.sv
sv/crl_checker.sv
tb/tb_catmull_rom_loop_evaluator.sv
